// ===== src/lrc_pkg.sv =====
package lrc_pkg;

    // field and datapath widths
    localparam int COEF_W  = 16;
    localparam int CONST_W = 24;
    localparam int REG_W   = 12;
    localparam int COORD_W = 20;
    localparam int NUM_W   = 41;
    localparam int MAG_W   = 40;
    localparam int DEN_W   = 16;
    localparam int QUO_W   = 21;
    localparam int SQ_W    = 41;
    localparam int DIST_W  = 42;

    // configuration register indexes and reset values
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;
    localparam logic [REG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [REG_W-1:0] HEIGHT_RESET = 12'd480;

    // per-item flags that travel alongside the dividers
    typedef struct packed {
        logic [3:0]       ovf;
        logic [3:0]       neg;
        logic             a_nz;
        logic             b_nz;
        logic [REG_W-1:0] w;
        logic [REG_W-1:0] h;
    } t_side;

endpackage

// ===== src/lrc_divider.sv =====
module lrc_divider
    import lrc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [MAG_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quot
);

    logic [DEN_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_low [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    // one restoring step per stage, high quotient bit first
    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [QUO_W-1:0] low_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in = i_num[QUO_W+DEN_W-1:QUO_W];
            assign low_in = i_num[QUO_W-1:0];
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign trial = {rem_in, low_in[QUO_W-1-k]};
        assign ge    = trial >= {1'b0, den_in};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_low[k] <= low_in;
                r_den[k] <= den_in;
                r_quo[k] <= {quo_in[QUO_W-2:0], ge};
            end
        end
    end

    assign o_quot = r_quo[QUO_W-1];

endmodule

// ===== src/line_rectangle_clip_unit.sv =====
// line_rectangle_clip_unit
// clips a line a*x + b*y + c = 0 against the rectangle [0,width] x [0,height]
// in channel: i_in_valid / o_in_ready with i_line_a, i_line_b, i_line_c
// out channel: o_out_valid / i_out_ready with o_found, start and end points
// config: i_cfg_we writes i_cfg_data into width (index 0) or height (index 1)
// every item gives exactly one result item
// pipeline: 5 front stages, 21 divider stages of one quotient bit each, 5 back stages
// throughput: one item per cycle unless the receiver stalls;
// the four border divisions run in parallel
// pipelined restoring dividers, one quotient bit per stage
// when the receiver stalls with a result held, the whole pipeline freezes
// and o_in_ready drops; nothing is lost or repeated
// reset clears all valid bits and sets width 640, height 480
module line_rectangle_clip_unit
    import lrc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [REG_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [COEF_W-1:0]  i_line_a,
    input  logic signed [COEF_W-1:0]  i_line_b,
    input  logic signed [CONST_W-1:0] i_line_c,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_found,
    output logic [COORD_W-1:0]        o_start_x,
    output logic [COORD_W-1:0]        o_start_y,
    output logic [COORD_W-1:0]        o_end_x,
    output logic [COORD_W-1:0]        o_end_y
);

    logic en;
    logic [REG_W-1:0] r_width, r_height;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default:    r_width  <= r_width;
            endcase
        end
    end

    // whole pipeline advances unless a held result is not taken
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // stage 1: capture item
    logic r1_v;
    logic signed [COEF_W-1:0]  r1_a, r1_b;
    logic signed [CONST_W-1:0] r1_c;
    logic [REG_W-1:0] r1_w, r1_h;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a <= i_line_a;
            r1_b <= i_line_b;
            r1_c <= i_line_c;
            r1_w <= r_width;
            r1_h <= r_height;
        end
    end

    // stage 2: border products a*w and b*h
    logic r2_v;
    logic signed [28:0] r2_aw, r2_bh;
    logic signed [COEF_W-1:0]  r2_a, r2_b;
    logic signed [CONST_W-1:0] r2_c;
    logic [REG_W-1:0] r2_w, r2_h;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_aw <= r1_a * $signed({1'b0, r1_w});
            r2_bh <= r1_b * $signed({1'b0, r1_h});
            r2_a  <= r1_a;
            r2_b  <= r1_b;
            r2_c  <= r1_c;
            r2_w  <= r1_w;
            r2_h  <= r1_h;
        end
    end

    // stage 3: numerators -(c*128 + p)*256
    logic r3_v;
    logic signed [NUM_W-1:0] r3_n0, r3_n1, r3_n3;
    logic signed [COEF_W-1:0] r3_a, r3_b;
    logic [REG_W-1:0] r3_w, r3_h;
    logic signed [31:0] c7, s1, s3;
    assign c7 = {r2_c[CONST_W-1], r2_c, 7'b0};
    assign s1 = c7 + {{3{r2_aw[28]}}, r2_aw};
    assign s3 = c7 + {{3{r2_bh[28]}}, r2_bh};
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_n0 <= -{{2{r2_c[CONST_W-1]}}, r2_c, 15'b0};
            r3_n1 <= -{s1[31], s1, 8'b0};
            r3_n3 <= -{s3[31], s3, 8'b0};
            r3_a  <= r2_a;
            r3_b  <= r2_b;
            r3_w  <= r2_w;
            r3_h  <= r2_h;
        end
    end

    // stage 4: magnitudes and quotient signs
    logic r4_v;
    logic [MAG_W-1:0] r4_m0, r4_m1, r4_m3;
    logic [DEN_W-1:0] r4_da, r4_db;
    logic [3:0] r4_neg;
    logic r4_anz, r4_bnz;
    logic [REG_W-1:0] r4_w, r4_h;
    logic signed [NUM_W-1:0] a0, a1, a3;
    assign a0 = r3_n0[NUM_W-1] ? -r3_n0 : r3_n0;
    assign a1 = r3_n1[NUM_W-1] ? -r3_n1 : r3_n1;
    assign a3 = r3_n3[NUM_W-1] ? -r3_n3 : r3_n3;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_m0  <= a0[MAG_W-1:0];
            r4_m1  <= a1[MAG_W-1:0];
            r4_m3  <= a3[MAG_W-1:0];
            r4_db  <= r3_b[COEF_W-1] ? DEN_W'(-r3_b) : r3_b;
            r4_da  <= r3_a[COEF_W-1] ? DEN_W'(-r3_a) : r3_a;
            r4_neg <= {r3_n3[NUM_W-1] ^ r3_a[COEF_W-1], r3_n0[NUM_W-1] ^ r3_a[COEF_W-1],
                       r3_n1[NUM_W-1] ^ r3_b[COEF_W-1], r3_n0[NUM_W-1] ^ r3_b[COEF_W-1]};
            r4_anz <= r3_a != '0;
            r4_bnz <= r3_b != '0;
            r4_w   <= r3_w;
            r4_h   <= r3_h;
        end
    end

    // stage 5: quotient overflow check, feeds the dividers
    logic r5_v;
    logic [MAG_W-1:0] r5_m0, r5_m1, r5_m3;
    logic [DEN_W-1:0] r5_da, r5_db;
    t_side r5_side;
    logic [MAG_W-1:0] lim_a, lim_b;
    assign lim_a = {3'b0, r4_da, 21'b0};
    assign lim_b = {3'b0, r4_db, 21'b0};
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_m0        <= r4_m0;
            r5_m1        <= r4_m1;
            r5_m3        <= r4_m3;
            r5_da        <= r4_da;
            r5_db        <= r4_db;
            r5_side.ovf  <= {r4_m3 >= lim_a, r4_m0 >= lim_a, r4_m1 >= lim_b, r4_m0 >= lim_b};
            r5_side.neg  <= r4_neg;
            r5_side.a_nz <= r4_anz;
            r5_side.b_nz <= r4_bnz;
            r5_side.w    <= r4_w;
            r5_side.h    <= r4_h;
        end
    end

    // four border divisions
    logic [QUO_W-1:0] q [4];
    lrc_divider u_div_left  (.i_clk, .i_en(en), .i_num(r5_m0), .i_den(r5_db), .o_quot(q[0]));
    lrc_divider u_div_right (.i_clk, .i_en(en), .i_num(r5_m1), .i_den(r5_db), .o_quot(q[1]));
    lrc_divider u_div_top   (.i_clk, .i_en(en), .i_num(r5_m0), .i_den(r5_da), .o_quot(q[2]));
    lrc_divider u_div_bot   (.i_clk, .i_en(en), .i_num(r5_m3), .i_den(r5_da), .o_quot(q[3]));

    // flags ride along the divider depth
    t_side r_side [QUO_W];
    logic [QUO_W-1:0] r_dv;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r5_side;
            for (int k = 1; k < QUO_W; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // stage 6: bounds check and border points
    logic r6_v;
    logic [3:0] r6_ok;
    logic [COORD_W-1:0] r6_px [4];
    logic [COORD_W-1:0] r6_py [4];
    t_side sd;
    logic [COORD_W-1:0] xmax, ymax;
    logic [3:0] inb;
    assign sd   = r_side[QUO_W-1];
    assign xmax = {sd.w, 8'b0};
    assign ymax = {sd.h, 8'b0};
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            inb[i] = !sd.ovf[i] && (q[i] == '0 || !sd.neg[i]) &&
                     q[i] <= {1'b0, (i < 2) ? ymax : xmax};
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_ok    <= {inb[3] && sd.a_nz, inb[2] && sd.a_nz,
                         inb[1] && sd.b_nz, inb[0] && sd.b_nz};
            r6_px[0] <= '0;
            r6_py[0] <= q[0][COORD_W-1:0];
            r6_px[1] <= xmax;
            r6_py[1] <= q[1][COORD_W-1:0];
            r6_px[2] <= q[2][COORD_W-1:0];
            r6_py[2] <= '0;
            r6_px[3] <= q[3][COORD_W-1:0];
            r6_py[3] <= ymax;
        end
    end

    // stage 7: first point and differences to later points
    logic r7_v;
    logic r7_has;
    logic [3:1] r7_cand;
    logic [COORD_W-1:0] r7_px [4];
    logic [COORD_W-1:0] r7_py [4];
    logic [COORD_W-1:0] r7_fx, r7_fy;
    logic signed [COORD_W:0] r7_dx [4];
    logic signed [COORD_W:0] r7_dy [4];
    logic [1:0] fidx;
    logic [COORD_W-1:0] fx, fy;
    always_comb begin
        fidx = 2'd3;
        if (r6_ok[0]) fidx = 2'd0;
        else if (r6_ok[1]) fidx = 2'd1;
        else if (r6_ok[2]) fidx = 2'd2;
        fx = r6_px[fidx];
        fy = r6_py[fidx];
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_has <= r6_ok != '0;
            r7_fx  <= fx;
            r7_fy  <= fy;
            for (int i = 1; i < 4; i++) begin
                r7_cand[i] <= r6_ok[i] && (r6_ok != '0) && (fidx < 2'(i));
            end
            for (int i = 0; i < 4; i++) begin
                r7_px[i] <= r6_px[i];
                r7_py[i] <= r6_py[i];
                r7_dx[i] <= $signed({1'b0, r6_px[i]}) - $signed({1'b0, fx});
                r7_dy[i] <= $signed({1'b0, r6_py[i]}) - $signed({1'b0, fy});
            end
        end
    end

    // stage 8: squares
    logic r8_v;
    logic r8_has;
    logic [3:1] r8_cand;
    logic [COORD_W-1:0] r8_px [4];
    logic [COORD_W-1:0] r8_py [4];
    logic [COORD_W-1:0] r8_fx, r8_fy;
    logic [SQ_W-1:0] r8_sx [4];
    logic [SQ_W-1:0] r8_sy [4];
    logic signed [2*COORD_W+1:0] sqx [4];
    logic signed [2*COORD_W+1:0] sqy [4];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sqx[i] = r7_dx[i] * r7_dx[i];
            sqy[i] = r7_dy[i] * r7_dy[i];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_has  <= r7_has;
            r8_cand <= r7_cand;
            r8_fx   <= r7_fx;
            r8_fy   <= r7_fy;
            for (int i = 1; i < 4; i++) begin
                r8_px[i] <= r7_px[i];
                r8_py[i] <= r7_py[i];
                r8_sx[i] <= sqx[i][SQ_W-1:0];
                r8_sy[i] <= sqy[i][SQ_W-1:0];
            end
        end
    end

    // stage 9: squared distances
    logic r9_v;
    logic r9_has;
    logic [3:1] r9_cand;
    logic [COORD_W-1:0] r9_px [4];
    logic [COORD_W-1:0] r9_py [4];
    logic [COORD_W-1:0] r9_fx, r9_fy;
    logic [DIST_W-1:0] r9_d [4];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_has  <= r8_has;
            r9_cand <= r8_cand;
            r9_fx   <= r8_fx;
            r9_fy   <= r8_fy;
            for (int i = 1; i < 4; i++) begin
                r9_px[i] <= r8_px[i];
                r9_py[i] <= r8_py[i];
                r9_d[i]  <= {1'b0, r8_sx[i]} + {1'b0, r8_sy[i]};
            end
        end
    end

    // stage 10: farthest later point, first one kept on a tie
    logic [DIST_W-1:0] best;
    logic [1:0] sec;
    logic sec_ok;
    logic r_found;
    logic [COORD_W-1:0] r_sx, r_sy, r_ex, r_ey;
    always_comb begin
        best   = '0;
        sec    = 2'd1;
        sec_ok = 1'b0;
        for (int i = 1; i < 4; i++) begin
            if (r9_cand[i] && r9_d[i] > best) begin
                best   = r9_d[i];
                sec    = 2'(i);
                sec_ok = 1'b1;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_found <= r9_has && sec_ok;
            r_sx    <= (r9_has && sec_ok) ? r9_fx : '0;
            r_sy    <= (r9_has && sec_ok) ? r9_fy : '0;
            r_ex    <= (r9_has && sec_ok) ? r9_px[sec] : '0;
            r_ey    <= (r9_has && sec_ok) ? r9_py[sec] : '0;
        end
    end

    // valid bits
    logic r_out_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            r_dv    <= '0;
            r6_v    <= 1'b0;
            r7_v    <= 1'b0;
            r8_v    <= 1'b0;
            r9_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r1_v    <= i_in_valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r5_v    <= r4_v;
            r_dv    <= {r_dv[QUO_W-2:0], r5_v};
            r6_v    <= r_dv[QUO_W-1];
            r7_v    <= r6_v;
            r8_v    <= r7_v;
            r9_v    <= r8_v;
            r_out_v <= r9_v;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_found     = r_found;
    assign o_start_x   = r_sx;
    assign o_start_y   = r_sy;
    assign o_end_x     = r_ex;
    assign o_end_y     = r_ey;

endmodule
